// ----- design/link_frame_deframer_top_defines.svh -----
// Assertion macros for the link frame deframer checker.
// Needs nothing else; taken in by the checker file only.
`ifndef LINK_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define LINK_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LFD_ASSERT_IMPLY(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define LFD_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lfd_pkg.sv -----
// Shared types and constants of the link frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lfd_pkg;

    // Configuration port geometry: eight registers at byte addresses 4*i.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[4:2]).
    localparam logic [2:0] REG_FLAG     = 3'd0;
    localparam logic [2:0] REG_ESCAPE   = 3'd1;
    localparam logic [2:0] REG_FLAG_SC  = 3'd2;
    localparam logic [2:0] REG_ESC_SC   = 3'd3;
    localparam logic [2:0] REG_ADDR_CMD = 3'd4;
    localparam logic [2:0] REG_ADDR_RPL = 3'd5;
    localparam logic [2:0] REG_INFO_MSK = 3'd6;
    localparam logic [2:0] REG_SU_MAP   = 3'd7;

    // Reset values of the registers.
    localparam logic [7:0]  RST_FLAG     = 8'd126;
    localparam logic [7:0]  RST_ESCAPE   = 8'd125;
    localparam logic [7:0]  RST_FLAG_SC  = 8'd94;
    localparam logic [7:0]  RST_ESC_SC   = 8'd93;
    localparam logic [7:0]  RST_ADDR_CMD = 8'd3;
    localparam logic [7:0]  RST_ADDR_RPL = 8'd1;
    localparam logic [7:0]  RST_INFO_MSK = 8'd191;
    localparam logic [15:0] RST_SU_MAP   = 16'd2218;

    // Result kinds.
    localparam logic [1:0] K_PAYLOAD  = 2'd0;
    localparam logic [1:0] K_SU_OK    = 2'd1;
    localparam logic [1:0] K_INFO_OK  = 2'd2;
    localparam logic [1:0] K_INFO_BAD = 2'd3;

    // Result queue geometry: room for two words per accepted byte.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic [7:0]  flag_byte;
        logic [7:0]  escape_byte;
        logic [7:0]  flag_stuff_code;
        logic [7:0]  escape_stuff_code;
        logic [7:0]  addr_command;
        logic [7:0]  addr_reply;
        logic [7:0]  info_ctrl_mask;
        logic [15:0] su_nibble_map;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] frame_address;
        logic [7:0] frame_control;
        logic       last;
    } t_res;

    // Results released by one accepted byte, in order.
    typedef struct packed {
        logic [1:0] cnt;
        t_res       res0;
        t_res       res1;
    } t_step;

endpackage

`default_nettype wire

// ----- design/lfd_regs.sv -----
// Configuration registers of the link frame deframer behind the APB-style port.
// Depends on lfd_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module lfd_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [2:0]                  i_index,
    input  logic [lfd_pkg::PDATA_W-1:0] i_wdata,
    output logic [lfd_pkg::PDATA_W-1:0] o_rdata,
    output lfd_pkg::t_cfg               o_cfg
);
    import lfd_pkg::*;

    t_cfg r_cfg;

    // Register writes; only the low bits of each word are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte         <= RST_FLAG;
            r_cfg.escape_byte       <= RST_ESCAPE;
            r_cfg.flag_stuff_code   <= RST_FLAG_SC;
            r_cfg.escape_stuff_code <= RST_ESC_SC;
            r_cfg.addr_command      <= RST_ADDR_CMD;
            r_cfg.addr_reply        <= RST_ADDR_RPL;
            r_cfg.info_ctrl_mask    <= RST_INFO_MSK;
            r_cfg.su_nibble_map     <= RST_SU_MAP;
        end else if (i_wr) begin
            case (i_index)
                REG_FLAG:     r_cfg.flag_byte         <= i_wdata[7:0];
                REG_ESCAPE:   r_cfg.escape_byte       <= i_wdata[7:0];
                REG_FLAG_SC:  r_cfg.flag_stuff_code   <= i_wdata[7:0];
                REG_ESC_SC:   r_cfg.escape_stuff_code <= i_wdata[7:0];
                REG_ADDR_CMD: r_cfg.addr_command      <= i_wdata[7:0];
                REG_ADDR_RPL: r_cfg.addr_reply        <= i_wdata[7:0];
                REG_INFO_MSK: r_cfg.info_ctrl_mask    <= i_wdata[7:0];
                REG_SU_MAP:   r_cfg.su_nibble_map     <= i_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back, zero extended.
    always_comb begin
        case (i_index)
            REG_FLAG:     o_rdata = {24'd0, r_cfg.flag_byte};
            REG_ESCAPE:   o_rdata = {24'd0, r_cfg.escape_byte};
            REG_FLAG_SC:  o_rdata = {24'd0, r_cfg.flag_stuff_code};
            REG_ESC_SC:   o_rdata = {24'd0, r_cfg.escape_stuff_code};
            REG_ADDR_CMD: o_rdata = {24'd0, r_cfg.addr_command};
            REG_ADDR_RPL: o_rdata = {24'd0, r_cfg.addr_reply};
            REG_INFO_MSK: o_rdata = {24'd0, r_cfg.info_ctrl_mask};
            REG_SU_MAP:   o_rdata = {16'd0, r_cfg.su_nibble_map};
            default:      o_rdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- design/lfd_core.sv -----
// Frame recogniser: phase machine, destuffing, one-byte hold-back and XOR check.
// Depends on lfd_pkg for t_cfg, t_step and the result kinds.
`default_nettype none

module lfd_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_abort,
    input  lfd_pkg::t_cfg i_cfg,
    output lfd_pkg::t_step o_step
);
    import lfd_pkg::*;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_FLAG   = 3'd1;
    localparam logic [2:0] PH_ADDR   = 3'd2;
    localparam logic [2:0] PH_CTRL   = 3'd3;
    localparam logic [2:0] PH_SUWAIT = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;

    // Hold-back register together with the payload words it releases.
    typedef struct packed {
        logic       valid;
        logic [7:0] held;
        logic [7:0] check;
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_hold;

    logic [2:0] r_phase,   n_phase;
    logic [7:0] r_saved_address, n_saved_address;
    logic [7:0] r_saved_control, n_saved_control;
    logic       r_held_valid, r_esc_pending, n_esc_pending;
    logic [7:0] r_held_byte, r_check;

    t_hold      h;
    logic       has_end;
    logic [1:0] end_kind;
    logic       is_info;
    logic       is_su;
    t_res       end_res;
    t_res       pay0_res;
    t_res       pay1_res;

    // Push a byte into the hold-back slot, releasing the old one as payload.
    function automatic t_hold deliver(input t_hold hin, input logic [7:0] b);
        t_hold ho;
        ho = hin;
        if (hin.valid) begin
            if (hin.n == 2'd0) begin
                ho.b0 = hin.held;
            end else begin
                ho.b1 = hin.held;
            end
            ho.n     = hin.n + 2'd1;
            ho.check = hin.check ^ hin.held;
        end
        ho.held  = b;
        ho.valid = 1'b1;
        return ho;
    endfunction

    // Next state and released results for the byte on the input.
    always_comb begin
        h               = '{valid: r_held_valid, held: r_held_byte, check: r_check,
                            n: 2'd0, b0: 8'd0, b1: 8'd0};
        n_phase         = r_phase;
        n_saved_address = r_saved_address;
        n_saved_control = r_saved_control;
        n_esc_pending   = r_esc_pending;
        has_end         = 1'b0;
        end_kind        = K_SU_OK;
        is_info         = (i_rx_byte & i_cfg.info_ctrl_mask) == 8'd0;
        is_su           = (i_rx_byte[6:4] == 3'd0) && i_cfg.su_nibble_map[i_rx_byte[3:0]];

        if (i_abort) begin
            n_phase       = PH_START;
            h.valid       = 1'b0;
            h.held        = 8'd0;
            h.check       = 8'd0;
            n_esc_pending = 1'b0;
        end else begin
            case (r_phase)
                PH_FLAG: begin
                    if (i_rx_byte == i_cfg.addr_command || i_rx_byte == i_cfg.addr_reply) begin
                        n_saved_address = i_rx_byte;
                        n_phase         = PH_ADDR;
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_ADDR: begin
                    if (is_info || is_su) begin
                        n_saved_control = i_rx_byte;
                        n_phase         = PH_CTRL;
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_CTRL: begin
                    if (i_rx_byte == (r_saved_address ^ r_saved_control)) begin
                        h.valid       = 1'b0;
                        h.held        = 8'd0;
                        h.check       = 8'd0;
                        n_esc_pending = 1'b0;
                        n_phase = ((r_saved_control & i_cfg.info_ctrl_mask) == 8'd0) ?
                                  PH_DATA : PH_SUWAIT;
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_SUWAIT: begin
                    if (i_rx_byte == i_cfg.flag_byte) begin
                        has_end  = 1'b1;
                        end_kind = K_SU_OK;
                    end
                    n_phase = PH_START;
                end
                PH_DATA: begin
                    if (i_rx_byte == i_cfg.flag_byte) begin
                        // Closing flag: a dangling escape counts as a literal byte.
                        if (r_esc_pending) begin
                            h = deliver(h, i_cfg.escape_byte);
                        end
                        has_end  = 1'b1;
                        end_kind = (h.valid && h.held == h.check) ? K_INFO_OK : K_INFO_BAD;
                        h.valid       = 1'b0;
                        h.held        = 8'd0;
                        h.check       = 8'd0;
                        n_esc_pending = 1'b0;
                        n_phase       = PH_START;
                    end else if (r_esc_pending) begin
                        n_esc_pending = 1'b0;
                        if (i_rx_byte == i_cfg.flag_stuff_code) begin
                            h = deliver(h, i_cfg.flag_byte);
                        end else if (i_rx_byte == i_cfg.escape_stuff_code) begin
                            h = deliver(h, i_cfg.escape_byte);
                        end else begin
                            // Bad pair: literal escape, then the byte on its own.
                            h = deliver(h, i_cfg.escape_byte);
                            if (i_rx_byte == i_cfg.escape_byte) begin
                                n_esc_pending = 1'b1;
                            end else begin
                                h = deliver(h, i_rx_byte);
                            end
                        end
                    end else if (i_rx_byte == i_cfg.escape_byte) begin
                        n_esc_pending = 1'b1;
                    end else begin
                        h = deliver(h, i_rx_byte);
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == i_cfg.flag_byte) ? PH_FLAG : PH_START;
                end
            endcase
        end
    end

    // Order the released words: payload first, end result last.
    always_comb begin
        end_res  = '{kind: end_kind, payload_byte: 8'd0, frame_address: r_saved_address,
                     frame_control: r_saved_control, last: 1'b1};
        pay0_res = '{kind: K_PAYLOAD, payload_byte: h.b0, frame_address: r_saved_address,
                     frame_control: r_saved_control, last: 1'b0};
        pay1_res = '{kind: K_PAYLOAD, payload_byte: h.b1, frame_address: r_saved_address,
                     frame_control: r_saved_control, last: 1'b0};
        o_step.cnt  = i_accept ? (h.n + {1'b0, has_end}) : 2'd0;
        o_step.res0 = (h.n != 2'd0) ? pay0_res : end_res;
        o_step.res1 = (h.n == 2'd2) ? pay1_res : end_res;
    end

    // Frame state, updated on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_START;
            r_saved_address <= 8'd0;
            r_saved_control <= 8'd0;
            r_held_valid    <= 1'b0;
            r_held_byte     <= 8'd0;
            r_esc_pending   <= 1'b0;
            r_check         <= 8'd0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_saved_address <= n_saved_address;
            r_saved_control <= n_saved_control;
            r_held_valid    <= h.valid;
            r_held_byte     <= h.held;
            r_esc_pending   <= n_esc_pending;
            r_check         <= h.check;
        end
    end

endmodule

`default_nettype wire

// ----- design/lfd_res_fifo.sv -----
// Result queue: takes up to two words a cycle, hands out one word a cycle when popped.
// Depends on lfd_pkg for t_step, t_res and the queue geometry.
`default_nettype none

module lfd_res_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lfd_pkg::t_step            i_step,
    input  logic                      i_pop,
    output lfd_pkg::t_res             o_head,
    output logic [lfd_pkg::CNT_W-1:0] o_count
);
    import lfd_pkg::*;

    t_res             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wptr_1;

    assign wptr_1 = r_wptr + PTR_W'(1);

    // Storage writes: first word at the write pointer, second one after it.
    always_ff @(posedge i_clk) begin
        if (i_step.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_step.res0;
        end
        if (i_step.cnt == 2'd2) begin
            r_mem[wptr_1] <= i_step.res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(i_step.cnt);
            r_rptr  <= r_rptr + PTR_W'(i_pop);
            r_count <= r_count + CNT_W'(i_step.cnt) - CNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- design/link_frame_deframer_top.sv -----
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall  i_rx_byte, i_abort
// result    out        o_out_valid / i_out_stall o_kind, o_payload_byte, o_frame_address,
//                                               o_frame_control, o_last
// config    in         psel / penable / pwrite  paddr, pwdata, prdata, pready
//
// A byte is processed in the cycle it is accepted; its results (none, one or two words) are
// registered in the result queue and leave it in order, one word per cycle while not stalled.
// One byte can be accepted every cycle while the four-word result queue has room for two
// more words; the sustained rate is set by the one-word-a-cycle output side.
// Synchronous active-low reset returns frame state, queue and registers to defaults.
// Output stall only fills the queue; input stall rises once it holds three or more words.
// Top level of the link frame deframer; depends on lfd_pkg, lfd_regs, lfd_core and
// lfd_res_fifo.
`default_nettype none

module link_frame_deframer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_abort,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_payload_byte,
    output logic [7:0]                  o_frame_address,
    output logic [7:0]                  o_frame_control,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfd_pkg::PADDR_W-1:0] paddr,
    input  logic [lfd_pkg::PDATA_W-1:0] pwdata,
    output logic [lfd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import lfd_pkg::*;

    t_cfg             cfg;
    t_step            step;
    t_res             head;
    logic [CNT_W-1:0] count;
    logic             accept;
    logic             pop;
    logic             cfg_wr;

    // Handshakes.
    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite & pready;
    assign o_in_stall  = count > CNT_W'(FIFO_DEPTH - 2);
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = count != '0;
    assign pop         = o_out_valid & ~i_out_stall;

    lfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_index (paddr[4:2]),
        .i_wdata (pwdata),
        .o_rdata (prdata),
        .o_cfg   (cfg)
    );

    lfd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_abort   (i_abort),
        .i_cfg     (cfg),
        .o_step    (step)
    );

    lfd_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (count)
    );

    // Result word fields.
    assign o_kind          = head.kind;
    assign o_payload_byte  = head.payload_byte;
    assign o_frame_address = head.frame_address;
    assign o_frame_control = head.frame_control;
    assign o_last          = head.last;

endmodule

`default_nettype wire

// ----- design/lfd_checker.sv -----
// Port-level checker of the link frame deframer, bound to the top level.
// Depends on link_frame_deframer_top_defines.svh for the assertion macros.
`default_nettype none
`include "link_frame_deframer_top_defines.svh"

module lfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_abort,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_payload_byte
);

    // Reset leaves no word waiting at the output.
    `LFD_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid, "output valid after reset")

    // The input is only held off while results wait.
    `LFD_ASSERT_IMPLY(a_stall_needs_data, i_clk, !i_rst_n, o_in_stall, o_out_valid, "input stalled with empty output")

    // An accepted abort into an empty block releases nothing.
    `LFD_ASSERT_NEXT(a_abort_silent, i_clk, !i_rst_n, i_in_valid && !o_in_stall && i_abort && !o_out_valid, !o_out_valid, "abort produced a result")

    // A stalled result word holds.
    `LFD_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_payload_byte), "stalled result changed")

endmodule

bind link_frame_deframer_top lfd_checker u_lfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_abort        (i_abort),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kind         (o_kind),
    .o_payload_byte (o_payload_byte)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for link_frame_deframer_top: a scripted byte sequence, then random
// framed traffic under several register settings, checked word by word against a predictor.
// Depends on lfd_pkg and the link_frame_deframer_top RTL only.
`timescale 1ns / 1ps

module tb_top;

    import lfd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYC   = 10;
    localparam int N_PHASES     = 8;
    localparam int BYTES_PER_PH = 135;
    localparam int SCRIPT_LEN   = 28;

    // Frame phases of the predictor.
    typedef enum logic [2:0] {
        PH_START, PH_FLAG, PH_ADDR, PH_CTRL, PH_SUWAIT, PH_DATA
    } t_frame_phase;

    // One row of the scripted byte sequence; chk marks a row with a known frame end.
    typedef struct {
        logic [7:0] rx;
        logic       ab;
        logic       chk;
        logic [1:0] kind;
    } t_rx_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [7:0]          i_rx_byte;
    logic                i_abort;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [1:0]          o_kind;
    logic [7:0]          o_payload_byte;
    logic [7:0]          o_frame_address;
    logic [7:0]          o_frame_control;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predictor state and its copy of the registers.
    t_cfg         cfg;
    t_frame_phase fr_phase;
    logic [7:0]   hdr_addr;
    logic [7:0]   hdr_ctrl;
    logic         hold_vld;
    logic [7:0]   hold_byte;
    logic         esc_seen;
    logic [7:0]   pay_xor;

    t_res words_due[$];
    t_res got_want;

    int err_cnt   = 0;
    int n_sent    = 0;
    int n_words   = 0;
    int n_ends    = 0;
    int n_cfg     = 0;
    int cyc_cnt   = 0;
    int snd_idle  = 19;
    int rcv_idle  = 45;
    int hold_left = 0;

    // Scripted bytes under the reset settings: repeated flag, supervisory frame, info frame
    // with both stuffed pairs and an escape before a plain byte, an info frame with an escape
    // right before the closing flag and no payload, and an abort with an extreme byte.
    t_rx_row rx_script [SCRIPT_LEN] = '{
        '{8'h7E, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h7E, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h7E, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h03, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h01, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h02, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h7E, 1'b0, 1'b1, K_SU_OK},
        '{8'h7E, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h01, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h00, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h01, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h7D, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h5E, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h7D, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h5D, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h7D, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h41, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h3F, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h7E, 1'b0, 1'b1, K_INFO_OK},
        '{8'h7E, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h03, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h40, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h43, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h7D, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h7E, 1'b0, 1'b1, K_INFO_BAD},
        '{8'h7E, 1'b0, 1'b0, K_PAYLOAD},
        '{8'h03, 1'b0, 1'b0, K_PAYLOAD},
        '{8'hFF, 1'b1, 1'b0, K_PAYLOAD}
    };

    link_frame_deframer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .i_abort         (i_abort),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_payload_byte  (o_payload_byte),
        .o_frame_address (o_frame_address),
        .o_frame_control (o_frame_control),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Run limit, counted in cycles.
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Queue a predicted result word.
    function automatic void push_word(logic [1:0] kind, logic [7:0] pay, logic last);
        t_res w;
        w.kind          = kind;
        w.payload_byte  = pay;
        w.frame_address = hdr_addr;
        w.frame_control = hdr_ctrl;
        w.last          = last;
        words_due.push_back(w);
    endfunction

    // Release the held payload byte and hold the new one back.
    function automatic void release_byte(logic [7:0] b);
        if (hold_vld) begin
            push_word(K_PAYLOAD, hold_byte, 1'b0);
            pay_xor ^= hold_byte;
        end
        hold_byte = b;
        hold_vld  = 1'b1;
    endfunction

    function automatic void clear_frame();
        fr_phase  = PH_START;
        hold_vld  = 1'b0;
        hold_byte = 8'h00;
        esc_seen  = 1'b0;
        pay_xor   = 8'h00;
    endfunction

    // Predict the words that one accepted byte releases.
    function automatic void deframe_byte(logic [7:0] b, logic ab);
        logic is_info;
        logic is_su;
        logic good;
        logic stuffed;
        if (ab) begin
            clear_frame();
            return;
        end
        case (fr_phase)
            PH_FLAG: begin
                if (b == cfg.addr_command || b == cfg.addr_reply) begin
                    hdr_addr = b;
                    fr_phase = PH_ADDR;
                end else begin
                    fr_phase = PH_START;
                end
            end
            PH_ADDR: begin
                is_info = (b & cfg.info_ctrl_mask) == 8'h00;
                is_su   = (b & 8'h70) == 8'h00 && cfg.su_nibble_map[b[3:0]];
                if (is_info || is_su) begin
                    hdr_ctrl = b;
                    fr_phase = PH_CTRL;
                end else begin
                    fr_phase = PH_START;
                end
            end
            PH_CTRL: begin
                if (b == (hdr_addr ^ hdr_ctrl)) begin
                    clear_frame();
                    fr_phase = ((hdr_ctrl & cfg.info_ctrl_mask) == 8'h00) ?
                               PH_DATA : PH_SUWAIT;
                end else begin
                    fr_phase = PH_START;
                end
            end
            PH_SUWAIT: begin
                if (b == cfg.flag_byte)
                    push_word(K_SU_OK, 8'h00, 1'b1);
                fr_phase = PH_START;
            end
            PH_DATA: begin
                if (b == cfg.flag_byte) begin
                    // A pending escape before the closing flag counts as a literal byte.
                    if (esc_seen)
                        release_byte(cfg.escape_byte);
                    good = hold_vld && hold_byte == pay_xor;
                    push_word(good ? K_INFO_OK : K_INFO_BAD, 8'h00, 1'b1);
                    clear_frame();
                end else begin
                    stuffed = 1'b0;
                    if (esc_seen) begin
                        esc_seen = 1'b0;
                        if (b == cfg.flag_stuff_code) begin
                            release_byte(cfg.flag_byte);
                            stuffed = 1'b1;
                        end else if (b == cfg.escape_stuff_code) begin
                            release_byte(cfg.escape_byte);
                            stuffed = 1'b1;
                        end else begin
                            release_byte(cfg.escape_byte);
                        end
                    end
                    if (!stuffed) begin
                        if (b == cfg.escape_byte)
                            esc_seen = 1'b1;
                        else
                            release_byte(b);
                    end
                end
            end
            default: begin
                fr_phase = (b == cfg.flag_byte) ? PH_FLAG : PH_START;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Compare every accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (words_due.size() == 0) begin
                $error("result word with none predicted: kind %0d payload %0h",
                       o_kind, o_payload_byte);
                err_cnt++;
            end else begin
                got_want = words_due.pop_front();
                check_field("kind", got_want.kind, o_kind);
                check_field("payload_byte", got_want.payload_byte, o_payload_byte);
                check_field("frame_address", got_want.frame_address, o_frame_address);
                check_field("frame_control", got_want.frame_control, o_frame_control);
                check_field("last", got_want.last, o_last);
                n_words++;
                if (got_want.last)
                    n_ends++;
            end
        end
    end

    // Receiver side: random stalls, or a long hold-off while hold_left runs down.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    // Offer one input word, with random idle cycles ahead of it, and predict on acceptance.
    task automatic send_word(input logic [7:0] b, input logic ab);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        i_abort    <= ab;
        do @(posedge i_clk); while (o_in_stall);
        deframe_byte(b, ab);
        n_sent++;
    endtask

    // Stop offering and wait until every predicted word has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write one register, then read it back.
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        logic [31:0] rd_want;
        rd_want = (idx == REG_SU_MAP) ? {16'h0000, val} : {24'h000000, val[7:0]};
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= rd_want;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_FLAG:     cfg.flag_byte         = val[7:0];
            REG_ESCAPE:   cfg.escape_byte       = val[7:0];
            REG_FLAG_SC:  cfg.flag_stuff_code   = val[7:0];
            REG_ESC_SC:   cfg.escape_stuff_code = val[7:0];
            REG_ADDR_CMD: cfg.addr_command      = val[7:0];
            REG_ADDR_RPL: cfg.addr_reply        = val[7:0];
            REG_INFO_MSK: cfg.info_ctrl_mask    = val[7:0];
            default:      cfg.su_nibble_map     = val;
        endcase
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== rd_want) begin
            $error("prdata mismatch at register %0d: expected %0h, got %0h",
                   idx, rd_want, prdata);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_cfg(input t_cfg c);
        cfg_write(REG_FLAG, {8'h00, c.flag_byte});
        cfg_write(REG_ESCAPE, {8'h00, c.escape_byte});
        cfg_write(REG_FLAG_SC, {8'h00, c.flag_stuff_code});
        cfg_write(REG_ESC_SC, {8'h00, c.escape_stuff_code});
        cfg_write(REG_ADDR_CMD, {8'h00, c.addr_command});
        cfg_write(REG_ADDR_RPL, {8'h00, c.addr_reply});
        cfg_write(REG_INFO_MSK, {8'h00, c.info_ctrl_mask});
        cfg_write(REG_SU_MAP, c.su_nibble_map);
        n_cfg++;
    endtask

    // Random settings with distinct flag and escape, and distinct stuff codes.
    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.flag_byte         = 8'($urandom);
        c.escape_byte       = c.flag_byte ^ 8'($urandom_range(1, 255));
        c.flag_stuff_code   = 8'($urandom);
        c.escape_stuff_code = c.flag_stuff_code ^ 8'($urandom_range(1, 255));
        c.addr_command      = 8'($urandom);
        c.addr_reply        = 8'($urandom);
        c.info_ctrl_mask    = 8'($urandom);
        c.su_nibble_map     = 16'($urandom);
        return c;
    endfunction

    // Payload bytes lean towards the delimiter, the escape and the stuff codes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return cfg.flag_byte;
            1:       return cfg.escape_byte;
            2:       return cfg.flag_stuff_code;
            3:       return cfg.escape_stuff_code;
            default: return 8'($urandom);
        endcase
    endfunction

    // Send a payload byte, replaced by its escape pair where needed.
    task automatic send_stuffed(input logic [7:0] b);
        if (b == cfg.flag_byte) begin
            send_word(cfg.escape_byte, 1'b0);
            send_word(cfg.flag_stuff_code, 1'b0);
        end else if (b == cfg.escape_byte) begin
            send_word(cfg.escape_byte, 1'b0);
            send_word(cfg.escape_stuff_code, 1'b0);
        end else begin
            send_word(b, 1'b0);
        end
    endtask

    // One random frame: mostly well formed, otherwise noise, a bad header, an abort,
    // a bare escape, a bad check or an escape just before the closing flag.
    task automatic send_frame();
        logic [7:0] a;
        logic [7:0] c;
        logic [7:0] h;
        logic [7:0] pb;
        logic [7:0] sum;
        int         n;
        int         r;
        r = $urandom_range(99);
        if (r < 10) begin
            n = $urandom_range(1, 4);
            repeat (n) send_word(8'($urandom), ($urandom_range(9) == 0));
            return;
        end
        a = ($urandom_range(1) == 1) ? cfg.addr_command : cfg.addr_reply;
        if (cfg.su_nibble_map != 16'h0000 && $urandom_range(2) == 0) begin
            n = $urandom_range(15);
            while (!cfg.su_nibble_map[n])
                n = $urandom_range(15);
            c    = 8'(n);
            c[7] = 1'($urandom_range(1));
        end else begin
            c = 8'($urandom) & ~cfg.info_ctrl_mask;
        end
        h = a ^ c;
        if (r < 15)
            h = h ^ 8'($urandom_range(1, 255));
        send_word(cfg.flag_byte, 1'b0);
        send_word(a, 1'b0);
        send_word(c, 1'b0);
        send_word(h, 1'b0);
        if ((c & cfg.info_ctrl_mask) != 8'h00) begin
            send_word((r < 20) ? 8'($urandom) : cfg.flag_byte, 1'b0);
            return;
        end
        n   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        sum = 8'h00;
        repeat (n) begin
            pb  = pick_byte();
            sum = sum ^ pb;
            send_stuffed(pb);
        end
        if (r >= 15 && r < 18) begin
            send_word(8'($urandom), 1'b1);
            return;
        end
        if (r >= 18 && r < 22) begin
            send_word(cfg.escape_byte, 1'b0);
            send_word(8'($urandom), 1'b0);
        end
        if (n > 0)
            send_stuffed((r >= 22 && r < 26) ? 8'($urandom) : sum);
        if (r >= 26 && r < 29)
            send_word(cfg.escape_byte, 1'b0);
        send_word(cfg.flag_byte, 1'b0);
    endtask

    // Main sequence: reset, scripted bytes, then random phases under changing settings.
    initial begin
        t_cfg next_cfg;
        int   target;
        int   midway;
        logic paused;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_byte   = 8'h00;
        i_abort     = 1'b0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cfg = '{RST_FLAG, RST_ESCAPE, RST_FLAG_SC, RST_ESC_SC,
                RST_ADDR_CMD, RST_ADDR_RPL, RST_INFO_MSK, RST_SU_MAP};
        hdr_addr = 8'h00;
        hdr_ctrl = 8'h00;
        clear_frame();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Scripted bytes; rows with a known frame end are checked against the prediction.
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            send_word(rx_script[i].rx, rx_script[i].ab);
            if (rx_script[i].chk) begin
                if (words_due.size() == 0 || words_due[$].kind != rx_script[i].kind
                        || !words_due[$].last) begin
                    $error("frame end mismatch at script row %0d: expected kind %0d",
                           i, rx_script[i].kind);
                    err_cnt++;
                end
            end
        end
        wait_drained();

        // Random phases: reset values, all-low and all-high extremes, then random settings.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       next_cfg = '{RST_FLAG, RST_ESCAPE, RST_FLAG_SC, RST_ESC_SC,
                                      RST_ADDR_CMD, RST_ADDR_RPL, RST_INFO_MSK, RST_SU_MAP};
                1:       next_cfg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000};
                2:       next_cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF};
                default: next_cfg = rand_cfg();
            endcase
            apply_cfg(next_cfg);
            case (p % 3)
                0: begin
                    snd_idle = 19;
                    rcv_idle = 45;
                end
                1: begin
                    snd_idle = 45;
                    rcv_idle = 19;
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase
            // A long receiver hold-off so that the result queue fills and the input stalls.
            if (p == 0 || p == 4)
                hold_left = 120;
            target = n_sent + BYTES_PER_PH;
            midway = n_sent + BYTES_PER_PH / 2;
            paused = 1'b0;
            while (n_sent < target) begin
                send_frame();
                if (!paused && n_sent >= midway) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        $display("Summary: %0d bytes sent under %0d register settings.", n_sent, n_cfg);
        $display("Summary: %0d result words checked, %0d of them frame ends.", n_words, n_ends);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/lfd_pkg.sv
design/lfd_regs.sv
design/lfd_core.sv
design/lfd_res_fifo.sv
design/link_frame_deframer_top.sv
design/lfd_checker.sv
tb/tb_top.sv
